// ----- hdl/sbrc_pkg.sv -----
// ---------------------------------------------------------------------------
// sbrc_pkg
// Shared types and constants for the scaled blit rounded corner mask block.
// ---------------------------------------------------------------------------
package sbrc_pkg;

    // Coordinate bits taken from each destination input field
    localparam int COORD_BITS = 13;
    // Signed width for the window and corner geometry
    localparam int GEO_W      = 20;
    // Rectangle and framebuffer dimension width
    localparam int DIM_W      = 14;
    // Source dimension and quotient width
    localparam int SRC_W      = 16;
    // Corner radius width
    localparam int RAD_W      = 12;
    // Dividend width: offset times source size
    localparam int PROD_W     = DIM_W + SRC_W;
    // Squared distance width
    localparam int SQ_W       = 2 * GEO_W;
    // APB address and data widths (registers sit at 8-byte spacing)
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    // Register map index
    typedef enum logic [2:0] {
        REG_REGION_X      = 3'd0,
        REG_REGION_Y      = 3'd1,
        REG_REGION_WIDTH  = 3'd2,
        REG_REGION_HEIGHT = 3'd3,
        REG_CLIP_WIDTH    = 3'd4,
        REG_CLIP_HEIGHT   = 3'd5,
        REG_SRC_DIMS      = 3'd6,
        REG_CORNER_RAD    = 3'd7
    } reg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic signed [15:0] region_x;
        logic signed [15:0] region_y;
        logic [DIM_W-1:0]   region_width;
        logic [DIM_W-1:0]   region_height;
        logic [DIM_W-1:0]   clip_width;
        logic [DIM_W-1:0]   clip_height;
        logic [31:0]        src_dims;
        logic [47:0]        corner_rad;
    } cfg_t;

    // Geometry front end to divider hand-off
    typedef struct packed {
        logic [PROD_W-1:0] num_x;
        logic [PROD_W-1:0] num_y;
        logic [DIM_W-1:0]  den_x;
        logic [DIM_W-1:0]  den_y;
        logic              in_window;
        logic              write_enable;
    } geo_t;

endpackage

// ----- hdl/sbrc_cfg.sv -----
// ---------------------------------------------------------------------------
// sbrc_cfg
// APB register file holding the window, clip, source size and radii.
// ---------------------------------------------------------------------------
module sbrc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbrc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbrc_pkg::DATA_W-1:0]  pwdata,
    output logic [sbrc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output sbrc_pkg::cfg_t               cfg_o
);
    import sbrc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg_o  = cfg_reg;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_REGION_X:      cfg_next.region_x      = signed'(pwdata[15:0]);
                REG_REGION_Y:      cfg_next.region_y      = signed'(pwdata[15:0]);
                REG_REGION_WIDTH:  cfg_next.region_width  = pwdata[DIM_W-1:0];
                REG_REGION_HEIGHT: cfg_next.region_height = pwdata[DIM_W-1:0];
                REG_CLIP_WIDTH:    cfg_next.clip_width    = pwdata[DIM_W-1:0];
                REG_CLIP_HEIGHT:   cfg_next.clip_height   = pwdata[DIM_W-1:0];
                REG_SRC_DIMS:      cfg_next.src_dims      = pwdata[31:0];
                REG_CORNER_RAD:    cfg_next.corner_rad    = pwdata[47:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            REG_REGION_X:      prdata = {48'd0, cfg_reg.region_x};
            REG_REGION_Y:      prdata = {48'd0, cfg_reg.region_y};
            REG_REGION_WIDTH:  prdata = {50'd0, cfg_reg.region_width};
            REG_REGION_HEIGHT: prdata = {50'd0, cfg_reg.region_height};
            REG_CLIP_WIDTH:    prdata = {50'd0, cfg_reg.clip_width};
            REG_CLIP_HEIGHT:   prdata = {50'd0, cfg_reg.clip_height};
            REG_SRC_DIMS:      prdata = {32'd0, cfg_reg.src_dims};
            REG_CORNER_RAD:    prdata = {16'd0, cfg_reg.corner_rad};
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- hdl/sbrc_geom.sv -----
// ---------------------------------------------------------------------------
// sbrc_geom
// Four-stage front end: input capture, clipping and corner pick, scale
// products with distance squares, and the rounded-corner compare.
// ---------------------------------------------------------------------------
module sbrc_geom (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [sbrc_pkg::COORD_BITS-1:0] in_x,
    input  logic [sbrc_pkg::COORD_BITS-1:0] in_y,
    input  sbrc_pkg::cfg_t                cfg,
    output logic                          out_valid,
    output sbrc_pkg::geo_t                out_geo
);
    import sbrc_pkg::*;

    // Stage 0: captured coordinates
    logic                  v0_reg;
    logic [COORD_BITS-1:0] px0_reg;
    logic [COORD_BITS-1:0] py0_reg;

    // Stage 1: window, window offsets, chosen corner offsets
    logic                    v1_reg;
    logic [DIM_W-1:0]        ox1_reg, oy1_reg;
    logic [DIM_W-1:0]        dvx1_reg, dvy1_reg;
    logic                    win1_reg, none1_reg;
    logic signed [GEO_W-1:0] dx1_reg, dy1_reg;
    logic [RAD_W-1:0]        r1_reg;

    // Stage 2: products and squares
    logic              v2_reg;
    logic [PROD_W-1:0] nx2_reg, ny2_reg;
    logic [DIM_W-1:0]  dvx2_reg, dvy2_reg;
    logic              win2_reg, none2_reg;
    logic [SQ_W-1:0]   dx2_reg, dy2_reg;
    logic [2*RAD_W-1:0] rr2_reg;

    // Stage 3: result
    logic v3_reg;
    geo_t geo3_reg;

    // Stage 1 combinational geometry
    logic signed [GEO_W-1:0] rx, ry, rw, rh, cw, ch;
    logic signed [GEO_W-1:0] sx, sy, ex, ey, ex_raw, ey_raw;
    logic signed [GEO_W-1:0] pxs, pys;
    logic signed [GEO_W-1:0] r_tl, r_tr, r_bl, r_br;
    logic signed [GEO_W-1:0] tlx, tly, trx, try_c, blx, bly, brx, bry;
    logic signed [GEO_W-1:0] cx, cy, offx, offy, winx, winy;
    logic [RAD_W-1:0]        rsel;
    logic                    none_c, inwin_c;
    logic [SRC_W-1:0]        sw, sh;

    always_comb begin
        rx  = GEO_W'(cfg.region_x);
        ry  = GEO_W'(cfg.region_y);
        rw  = signed'({{(GEO_W-DIM_W){1'b0}}, cfg.region_width});
        rh  = signed'({{(GEO_W-DIM_W){1'b0}}, cfg.region_height});
        cw  = signed'({{(GEO_W-DIM_W){1'b0}}, cfg.clip_width});
        ch  = signed'({{(GEO_W-DIM_W){1'b0}}, cfg.clip_height});
        pxs = signed'({{(GEO_W-COORD_BITS){1'b0}}, px0_reg});
        pys = signed'({{(GEO_W-COORD_BITS){1'b0}}, py0_reg});
        sw  = cfg.src_dims[15:0];
        sh  = cfg.src_dims[31:16];

        // Clip the rectangle to the framebuffer
        sx = (rx < 0) ? '0 : ((rx > cw) ? cw : rx);
        sy = (ry < 0) ? '0 : ((ry > ch) ? ch : ry);
        ex_raw = rx + rw;
        ey_raw = ry + rh;
        ex = (ex_raw < sx) ? sx : ((ex_raw > cw) ? cw : ex_raw);
        ey = (ey_raw < sy) ? sy : ((ey_raw > ch) ? ch : ey_raw);

        inwin_c = (pxs >= sx) && (pxs < ex) && (pys >= sy) && (pys < ey);
        offx = pxs - sx;
        offy = pys - sy;
        winx = ex - sx;
        winy = ey - sy;

        // Corner centres from the unclipped rectangle
        r_tl = signed'({{(GEO_W-RAD_W){1'b0}}, cfg.corner_rad[11:0]});
        r_tr = signed'({{(GEO_W-RAD_W){1'b0}}, cfg.corner_rad[23:12]});
        r_bl = signed'({{(GEO_W-RAD_W){1'b0}}, cfg.corner_rad[35:24]});
        r_br = signed'({{(GEO_W-RAD_W){1'b0}}, cfg.corner_rad[47:36]});
        tlx   = rx + r_tl;     tly = ry + r_tl;
        trx   = ex_raw - r_tr; try_c = ry + r_tr;
        blx   = rx + r_bl;     bly = ey_raw - r_bl;
        brx   = ex_raw - r_br; bry = ey_raw - r_br;

        // First corner whose quadrant holds the pixel wins
        none_c = 1'b0;
        cx     = '0;
        cy     = '0;
        rsel   = '0;
        if (pys <= tly && pxs <= tlx) begin
            cx = tlx; cy = tly; rsel = cfg.corner_rad[11:0];
        end else if (pys <= try_c && pxs >= trx) begin
            cx = trx; cy = try_c; rsel = cfg.corner_rad[23:12];
        end else if (pys >= bly && pxs <= blx) begin
            cx = blx; cy = bly; rsel = cfg.corner_rad[35:24];
        end else if (pys >= bry && pxs >= brx) begin
            cx = brx; cy = bry; rsel = cfg.corner_rad[47:36];
        end else begin
            none_c = 1'b1;
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Data path; the user must hold source sizes static while items are in flight, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (en) begin
            px0_reg   <= in_x;
            py0_reg   <= in_y;

            ox1_reg   <= inwin_c ? offx[DIM_W-1:0] : '0;
            oy1_reg   <= inwin_c ? offy[DIM_W-1:0] : '0;
            dvx1_reg  <= winx[DIM_W-1:0];
            dvy1_reg  <= winy[DIM_W-1:0];
            win1_reg  <= inwin_c;
            none1_reg <= none_c;
            dx1_reg   <= pxs - cx;
            dy1_reg   <= pys - cy;
            r1_reg    <= rsel;

            nx2_reg   <= PROD_W'(ox1_reg) * PROD_W'(sw);
            ny2_reg   <= PROD_W'(oy1_reg) * PROD_W'(sh);
            dvx2_reg  <= dvx1_reg;
            dvy2_reg  <= dvy1_reg;
            win2_reg  <= win1_reg;
            none2_reg <= none1_reg;
            dx2_reg   <= SQ_W'(dx1_reg * dx1_reg);
            dy2_reg   <= SQ_W'(dy1_reg * dy1_reg);
            rr2_reg   <= (2*RAD_W)'(r1_reg) * (2*RAD_W)'(r1_reg);

            geo3_reg.num_x        <= nx2_reg;
            geo3_reg.num_y        <= ny2_reg;
            geo3_reg.den_x        <= dvx2_reg;
            geo3_reg.den_y        <= dvy2_reg;
            geo3_reg.in_window    <= win2_reg;
            geo3_reg.write_enable <= win2_reg && (none2_reg ||
                ({1'b0, dx2_reg} + {1'b0, dy2_reg} <= (SQ_W+1)'(rr2_reg)));
        end
    end

    assign out_valid = v3_reg;
    assign out_geo   = geo3_reg;

endmodule

// ----- hdl/sbrc_div.sv -----
// ---------------------------------------------------------------------------
// sbrc_div
// Pipelined restoring divider pair: one quotient bit per stage for the
// source column and row, with the window and mask flags riding alongside.
// ---------------------------------------------------------------------------
module sbrc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  sbrc_pkg::geo_t               in_geo,
    output logic                         out_valid,
    output logic [sbrc_pkg::SRC_W-1:0]   out_qx,
    output logic [sbrc_pkg::SRC_W-1:0]   out_qy,
    output logic                         out_in_window,
    output logic                         out_write_enable
);
    import sbrc_pkg::*;

    localparam int NSTEP = SRC_W;

    logic [NSTEP:0]   v_reg;
    logic [DIM_W-1:0] remx_reg [NSTEP+1];
    logic [DIM_W-1:0] remy_reg [NSTEP+1];
    logic [SRC_W-1:0] lowx_reg [NSTEP+1];
    logic [SRC_W-1:0] lowy_reg [NSTEP+1];
    logic [SRC_W-1:0] qx_reg   [NSTEP+1];
    logic [SRC_W-1:0] qy_reg   [NSTEP+1];
    logic [DIM_W-1:0] dx_reg   [NSTEP+1];
    logic [DIM_W-1:0] dy_reg   [NSTEP+1];
    logic [NSTEP:0]   win_reg;
    logic [NSTEP:0]   we_reg;

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTEP-1:0], in_valid};
        end
    end

    // Load stage: upper dividend bits are already below the divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            remx_reg[0] <= in_geo.num_x[PROD_W-1:SRC_W];
            remy_reg[0] <= in_geo.num_y[PROD_W-1:SRC_W];
            lowx_reg[0] <= in_geo.num_x[SRC_W-1:0];
            lowy_reg[0] <= in_geo.num_y[SRC_W-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            dx_reg[0]   <= in_geo.den_x;
            dy_reg[0]   <= in_geo.den_y;
            win_reg[0]  <= in_geo.in_window;
            we_reg[0]   <= in_geo.write_enable;
        end
    end

    // One trial subtract per stage
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic [DIM_W:0]   tx, ty;
        logic             gex, gey;
        logic [DIM_W-1:0] nrx, nry;

        always_comb begin
            tx  = {remx_reg[k], lowx_reg[k][SRC_W-1]};
            ty  = {remy_reg[k], lowy_reg[k][SRC_W-1]};
            gex = (tx >= {1'b0, dx_reg[k]});
            gey = (ty >= {1'b0, dy_reg[k]});
            nrx = gex ? DIM_W'(tx - {1'b0, dx_reg[k]}) : tx[DIM_W-1:0];
            nry = gey ? DIM_W'(ty - {1'b0, dy_reg[k]}) : ty[DIM_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                remx_reg[k+1] <= nrx;
                remy_reg[k+1] <= nry;
                lowx_reg[k+1] <= {lowx_reg[k][SRC_W-2:0], 1'b0};
                lowy_reg[k+1] <= {lowy_reg[k][SRC_W-2:0], 1'b0};
                qx_reg[k+1]   <= {qx_reg[k][SRC_W-2:0], gex};
                qy_reg[k+1]   <= {qy_reg[k][SRC_W-2:0], gey};
                dx_reg[k+1]   <= dx_reg[k];
                dy_reg[k+1]   <= dy_reg[k];
                win_reg[k+1]  <= win_reg[k];
                we_reg[k+1]   <= we_reg[k];
            end
        end
    end

    assign out_valid        = v_reg[NSTEP];
    assign out_qx           = qx_reg[NSTEP];
    assign out_qy           = qy_reg[NSTEP];
    assign out_in_window    = win_reg[NSTEP];
    assign out_write_enable = we_reg[NSTEP];

endmodule

// ----- hdl/scaled_blit_rounded_corner_mask.sv -----
// ---------------------------------------------------------------------------
// scaled_blit_rounded_corner_mask
// Nearest-neighbor scaled blit coordinate generator with rounded-corner
// write mask, one destination pixel per clock while the output is not stalled.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_dst_x, s_dst_y
// m_        out        m_valid / m_ready    m_src_x, m_src_y, m_in_window,
//                                           m_write_enable
// APB       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// An accepted pixel passes through 4 geometry stages, a load stage and 16
// divider stages (one quotient bit each), then the output register. One
// transaction per clock is sustained while the output is not stalled.
// A stalled output freezes the whole pipeline; s_ready falls with it.
// aresetn is synchronous; it clears the valid bits and the config registers.
// ---------------------------------------------------------------------------
module scaled_blit_rounded_corner_mask (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbrc_pkg::ADDR_W-1:0]       paddr,
    input  logic [sbrc_pkg::DATA_W-1:0]       pwdata,
    output logic [sbrc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sbrc_pkg::COORD_BITS-1:0]   s_dst_x,
    input  logic [sbrc_pkg::COORD_BITS-1:0]   s_dst_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sbrc_pkg::SRC_W-1:0]        m_src_x,
    output logic [sbrc_pkg::SRC_W-1:0]        m_src_y,
    output logic                              m_in_window,
    output logic                              m_write_enable
);
    import sbrc_pkg::*;

    cfg_t             cfg;
    geo_t             geo;
    logic             geo_valid;
    logic             en;
    logic             dv_valid, dv_win, dv_we;
    logic [SRC_W-1:0] dv_qx, dv_qy;

    logic             m_valid_reg, m_valid_next;
    logic [SRC_W-1:0] src_x_reg, src_y_reg;
    logic             win_reg, we_reg;

    // Pipeline advances whenever the output slot is free or being taken
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    sbrc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    sbrc_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_x      (s_dst_x),
        .in_y      (s_dst_y),
        .cfg       (cfg),
        .out_valid (geo_valid),
        .out_geo   (geo)
    );

    sbrc_div u_div (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .in_valid         (geo_valid),
        .in_geo           (geo),
        .out_valid        (dv_valid),
        .out_qx           (dv_qx),
        .out_qy           (dv_qy),
        .out_in_window    (dv_win),
        .out_write_enable (dv_we)
    );

    // Output register
    assign m_valid_next = en ? dv_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            src_x_reg <= dv_win ? dv_qx : '0;
            src_y_reg <= dv_win ? dv_qy : '0;
            win_reg   <= dv_win;
            we_reg    <= dv_win && dv_we;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_src_x        = src_x_reg;
    assign m_src_y        = src_y_reg;
    assign m_in_window    = win_reg;
    assign m_write_enable = we_reg;

    // Checks
    a_we_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_write_enable || m_in_window))
        else $error("write enable outside window");

    a_zero_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_window) |-> (m_src_x == '0 && m_src_y == '0))
        else $error("nonzero source coordinate outside window");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready disagrees with output slot");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_src_x) && $stable(m_src_y)))
        else $error("output changed while stalled");

endmodule
